>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl of the can frame fifo
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising edge out of reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
		else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> rtl/core/canfifo_pkg.sv
// types and constants of the can frame ring fifo
`timescale 1ns / 1ps
package canfifo_pkg;

	// field widths
	localparam int ID_W          = 29;
	localparam int LEN_W         = 4;
	localparam int BYTES_W       = 64;
	localparam int OPCODE_W      = 2;
	localparam int RING_LENGTH_W = 8;
	localparam int FRAME_BYTES   = 8;

	// ring length after reset and byte count limit
	localparam logic [RING_LENGTH_W-1:0] RING_LENGTH_RESET = 8'd100;
	localparam logic [LEN_W-1:0]         MAX_BYTES         = 4'd8;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_TAKE  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

	// request from the producer side
	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [ID_W-1:0]     frame_id;
		logic [LEN_W-1:0]    frame_length;
		logic [BYTES_W-1:0]  frame_bytes;
	} in_item_t;

	// result toward the consumer side
	typedef struct packed {
		logic                status;
		logic [ID_W-1:0]     out_id;
		logic [LEN_W-1:0]    out_length;
		logic [BYTES_W-1:0]  out_bytes;
		logic                is_full;
		logic                is_empty;
	} out_item_t;

	// one stored frame
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [LEN_W-1:0]   len;
		logic [BYTES_W-1:0] bytes;
	} entry_t;

	// decision of the pointer unit for the current request
	typedef struct packed {
		logic put_ok;
		logic take_ok;
		logic status;
		logic full;
		logic empty;
	} ptr_ctl_t;

endpackage

>>> rtl/core/canfifo_ptr.sv
// slot pointers, ring length register and full / empty decisions
`timescale 1ns / 1ps
`include "assert_macros.svh"
module canfifo_ptr #(
	parameter int SLOTS = 128,
	localparam int PW = $clog2(SLOTS)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [canfifo_pkg::RING_LENGTH_W-1:0]  cfg_wdata,
	input  logic                                   go,
	input  logic [canfifo_pkg::OPCODE_W-1:0]       opcode,
	output logic [PW-1:0]                          wr_addr,
	output logic [PW-1:0]                          rd_addr,
	output canfifo_pkg::ptr_ctl_t                  ctl
);
	import canfifo_pkg::*;

	localparam int NW = PW + 1;
	localparam int CW = ((NW > RING_LENGTH_W) ? NW : RING_LENGTH_W) + 1;

	logic [RING_LENGTH_W-1:0] len_q;
	logic [PW-1:0]            wr_q, rd_q, wr_d, rd_d;
	logic [CW-1:0]            len_c;
	logic [CW-1:0]            eff_c;
	logic [NW-1:0]            eff;
	logic                     full_now, empty_now;

	// advance a pointer, wrapping at the effective length
	function automatic logic [PW-1:0] next_of(input logic [PW-1:0] p,
		input logic [NW-1:0] lim);
		logic [NW-1:0] n;
		n = {1'b0, p} + NW'(1);
		return (n >= lim) ? '0 : n[PW-1:0];
	endfunction

	// clamp ring length to the range 2 .. SLOTS
	always_comb begin
		len_c = CW'(len_q);
		if (len_c < CW'(2)) begin
			eff_c = CW'(2);
		end else if (len_c > CW'(SLOTS)) begin
			eff_c = CW'(SLOTS);
		end else begin
			eff_c = len_c;
		end
		eff = eff_c[NW-1:0];
	end

	assign full_now  = (next_of(wr_q, eff) == rd_q);
	assign empty_now = (wr_q == rd_q);

	// per request decision and next pointers
	always_comb begin
		ctl  = '0;
		wr_d = wr_q;
		rd_d = rd_q;
		case (opcode)
			OP_PUT: begin
				if (full_now) begin
					ctl.status = 1'b1;
				end else begin
					ctl.put_ok = 1'b1;
					wr_d       = next_of(wr_q, eff);
				end
			end
			OP_TAKE: begin
				if (empty_now) begin
					ctl.status = 1'b1;
				end else begin
					ctl.take_ok = 1'b1;
					rd_d        = next_of(rd_q, eff);
				end
			end
			OP_CLEAR: begin
				wr_d = '0;
				rd_d = '0;
			end
			default: begin
			end
		endcase
		ctl.full  = (next_of(wr_d, eff) == rd_d);
		ctl.empty = (wr_d == rd_d);
	end

	// pointer and length registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= RING_LENGTH_RESET;
			wr_q  <= '0;
			rd_q  <= '0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (go) begin
				wr_q <= wr_d;
				rd_q <= rd_d;
			end
		end
	end

	assign wr_addr = wr_q;
	assign rd_addr = rd_q;

	// checks
	`ASSERT_AT(a_put_moves_wr, clk, arst_n, go && ctl.put_ok |=> wr_q != $past(wr_q))
	`ASSERT_AT(a_refused_holds, clk, arst_n, go && ctl.status |=> $stable(wr_q) && $stable(rd_q))
	`ASSERT_NEVER(a_full_and_empty, clk, arst_n, ctl.full && ctl.empty)

endmodule

>>> rtl/core/can_frame_ring_fifo.sv
// can frame ring fifo top level: frame memory and result register
//
// channel   direction  handshake             payload
// in        request    in_valid / in_stall   in_data (opcode, frame)
// out       result     out_valid / out_stall out_data (status, frame, flags)
// cfg       write      cfg_we                cfg_wdata (ring length)
//
// one request a cycle while in_stall is low; its result shows in the cycle after acceptance
// the single read / single write port of the frame memory sets that rate
// reset clears both pointers and loads a ring length of 100, no clearing pass
// a held result stalls the input side until it is taken
`timescale 1ns / 1ps
`include "assert_macros.svh"
module can_frame_ring_fifo #(
	parameter int SLOTS = 128
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [canfifo_pkg::RING_LENGTH_W-1:0] cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  canfifo_pkg::in_item_t                 in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output canfifo_pkg::out_item_t                out_data
);
	import canfifo_pkg::*;

	localparam int PW = $clog2(SLOTS);

	logic          accept;
	logic [PW-1:0] wr_addr, rd_addr;
	ptr_ctl_t      ctl;
	entry_t        wr_entry;
	logic [LEN_W-1:0] len_c;
	entry_t        mem [SLOTS];

	logic          valid_s1;
	logic          status_s1, full_s1, empty_s1;
	entry_t        rd_s1;

	assign in_stall = valid_s1 && out_stall;
	assign accept   = in_valid && !in_stall;

	canfifo_ptr #(.SLOTS(SLOTS)) u_ptr (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.go       (accept),
		.opcode   (in_data.opcode),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.ctl      (ctl)
	);

	// clamp byte count and zero bytes past it
	always_comb begin
		len_c = (in_data.frame_length > MAX_BYTES) ? MAX_BYTES : in_data.frame_length;
		wr_entry.id  = in_data.frame_id;
		wr_entry.len = len_c;
		for (int i = 0; i < FRAME_BYTES; i++) begin
			wr_entry.bytes[i*8 +: 8] = (LEN_W'(i) < len_c) ? in_data.frame_bytes[i*8 +: 8]
				: 8'h00;
		end
	end

	// frame memory, registered read; zero unless a take succeeds
	always_ff @(posedge clk) begin
		if (accept && ctl.put_ok) begin
			mem[wr_addr] <= wr_entry;
		end
		if (accept) begin
			rd_s1 <= ctl.take_ok ? mem[rd_addr] : '0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= ctl.status;
			full_s1   <= ctl.full;
			empty_s1  <= ctl.empty;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	assign out_valid           = valid_s1;
	assign out_data.status     = status_s1;
	assign out_data.out_id     = rd_s1.id;
	assign out_data.out_length = rd_s1.len;
	assign out_data.out_bytes  = rd_s1.bytes;
	assign out_data.is_full    = full_s1;
	assign out_data.is_empty   = empty_s1;

	// checks
	`ASSERT_AT(a_accept_gives_result, clk, arst_n, accept |=> valid_s1)
	`ASSERT_AT(a_refused_no_data, clk, arst_n, valid_s1 && status_s1 |-> rd_s1 == '0)
	`ASSERT_NEVER(a_result_full_empty, clk, arst_n, valid_s1 && full_s1 && empty_s1)

endmodule

>>> tb/can_frame_ring_fifo_sb_pkg.sv
// scoreboard of the can frame ring fifo testbench: frame ring predictor and result check
`timescale 1ns / 1ps
package can_frame_ring_fifo_sb_pkg;
	import canfifo_pkg::*;

	localparam int   SLOTS          = 128;
	localparam logic STATUS_REFUSED = 1'b1;

	class frame_ring_scoreboard;
		logic [RING_LENGTH_W-1:0] ring_length;
		int unsigned              wr_slot;
		int unsigned              rd_slot;
		entry_t                   frames [SLOTS];
		bit                       slot_written [SLOTS];
		out_item_t                due_results [$];
		int                       mismatches;

		function new();
			ring_length = RING_LENGTH_RESET;
			wr_slot = 0;
			rd_slot = 0;
			mismatches = 0;
			foreach (slot_written[i]) slot_written[i] = 1'b0;
		endfunction

		// ring length clamped to the usable range
		function int unsigned span();
			int unsigned len;
			len = 32'(ring_length);
			if (len < 2) len = 2;
			if (len > SLOTS) len = SLOTS;
			return len;
		endfunction

		// pointer advance, anything at or past the end goes back to zero
		function int unsigned advance(int unsigned p);
			return (p + 1 >= span()) ? 0 : p + 1;
		endfunction

		function bit ring_full();
			return advance(wr_slot) == rd_slot;
		endfunction

		function bit ring_empty();
			return wr_slot == rd_slot;
		endfunction

		function void set_ring_length(logic [RING_LENGTH_W-1:0] value);
			ring_length = value;
		endfunction

		// a take now would read a slot that never held a frame
		function bit take_reads_unwritten();
			return !ring_empty() && !slot_written[rd_slot];
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// work out the result of one accepted request and queue it
		function void apply_request(in_item_t req);
			out_item_t          res;
			logic [LEN_W-1:0]   len;
			logic [BYTES_W-1:0] data;
			res = '0;
			case (req.opcode)
				OP_PUT: begin
					if (ring_full()) begin
						res.status = STATUS_REFUSED;
					end else begin
						len = (req.frame_length > MAX_BYTES) ? MAX_BYTES : req.frame_length;
						data = req.frame_bytes;
						// bytes past the count are cleared before storing
						if (len < MAX_BYTES) data &= (64'd1 << (8 * len)) - 64'd1;
						frames[wr_slot] = '{id: req.frame_id, len: len, bytes: data};
						slot_written[wr_slot] = 1'b1;
						wr_slot = advance(wr_slot);
					end
				end
				OP_TAKE: begin
					if (ring_empty()) begin
						res.status = STATUS_REFUSED;
					end else begin
						res.out_id = frames[rd_slot].id;
						res.out_length = frames[rd_slot].len;
						res.out_bytes = frames[rd_slot].bytes;
						rd_slot = advance(rd_slot);
					end
				end
				OP_CLEAR: begin
					wr_slot = 0;
					rd_slot = 0;
				end
				default: ;
			endcase
			res.is_full = ring_full();
			res.is_empty = ring_empty();
			due_results.push_back(res);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				mismatches++;
			end
		endfunction

		// compare one delivered result with the oldest queued one
		function void check_result(out_item_t got);
			out_item_t want;
			if (due_results.size() == 0) begin
				$error("result with no request outstanding: %h", got);
				mismatches++;
				return;
			end
			want = due_results.pop_front();
			compare_field("status", 64'(want.status), 64'(got.status));
			compare_field("out_id", 64'(want.out_id), 64'(got.out_id));
			compare_field("out_length", 64'(want.out_length), 64'(got.out_length));
			compare_field("out_bytes", want.out_bytes, got.out_bytes);
			compare_field("is_full", 64'(want.is_full), 64'(got.is_full));
			compare_field("is_empty", 64'(want.is_empty), 64'(got.is_empty));
		endfunction
	endclass

endpackage

>>> tb/can_frame_ring_fifo_tb.sv
// testbench top of the can frame ring fifo: clock, reset, drivers, monitor and watchdog
`timescale 1ns / 1ps
module can_frame_ring_fifo_tb;
	import canfifo_pkg::*;
	import can_frame_ring_fifo_sb_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 80;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [RING_LENGTH_W-1:0] cfg_wdata;
	logic                     in_valid;
	logic                     in_stall;
	in_item_t                 in_data;
	logic                     out_valid;
	logic                     out_stall;
	out_item_t                out_data;

	frame_ring_scoreboard sb;
	int                   results_taken = 0;
	int                   quiet_cycles = 0;

	can_frame_ring_fifo u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(out_data);
			results_taken++;
		end
	end

	// watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("** can_frame_ring_fifo: FAILED **");
				$finish;
			end
		end
	end

	// receiver stall pattern with two long hold-offs
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		int holds_done;
		out_stall = 1'b0;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && holds_done < 2 &&
					results_taken >= ((holds_done == 0) ? 100 : 420)) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 60);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 20);
					default: out_stall <= ($urandom_range(0, 99) < 70);
				endcase
			end
		end
	end

	// offer one request and hold it until accepted
	task automatic send_request(in_item_t req);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.apply_request(req);
	endtask

	task automatic pause(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// stop sending and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_ring_length(logic [RING_LENGTH_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		sb.set_ring_length(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic in_item_t frame_request(logic [OPCODE_W-1:0] op, logic [ID_W-1:0] id,
			logic [LEN_W-1:0] len, logic [BYTES_W-1:0] bytes);
		in_item_t req;
		req.opcode = op;
		req.frame_id = id;
		req.frame_length = len;
		req.frame_bytes = bytes;
		return req;
	endfunction

	// random request, weighted toward puts or takes
	function automatic in_item_t random_request(int put_pct);
		in_item_t req;
		int       pick;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0: req.frame_id = '0;
			1: req.frame_id = '1;
			default: req.frame_id = ID_W'($urandom());
		endcase
		req.frame_length = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(9, 15)) :
				LEN_W'($urandom_range(0, 8));
		req.frame_bytes = {$urandom(), $urandom()};
		if (pick < 3) req.opcode = OP_CLEAR;
		else if (pick < 5) req.opcode = OP_UNUSED;
		else if (pick < 5 + put_pct * 95 / 100) req.opcode = OP_PUT;
		else req.opcode = OP_TAKE;
		// never read a slot that was not filled since reset
		if (req.opcode == OP_TAKE && sb.take_reads_unwritten()) req.opcode = OP_CLEAR;
		return req;
	endfunction

	// one ring length, then a run of bursty random requests
	task automatic run_phase(logic [RING_LENGTH_W-1:0] len_value, int count, int put_pct);
		int burst_left;
		write_ring_length(len_value);
		burst_left = $urandom_range(1, 24);
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				pause($urandom_range(0, 8));
				burst_left = $urandom_range(1, 24);
			end
			send_request(random_request(put_pct));
			burst_left--;
		end
		settle();
	endtask

	// directed requests on the smallest ring: one frame fits
	task automatic run_directed();
		send_request(frame_request(OP_TAKE, '0, '0, '0));
		send_request(frame_request(OP_PUT, '1, 4'd8, '1));
		send_request(frame_request(OP_PUT, 29'h0ABCDEF, 4'd4, 64'h0123_4567_89AB_CDEF));
		send_request(frame_request(OP_TAKE, '0, '0, '0));
		send_request(frame_request(OP_TAKE, '1, '1, '1));
		// zero byte count clears all data bytes
		send_request(frame_request(OP_PUT, '0, 4'd0, '1));
		send_request(frame_request(OP_TAKE, '0, '0, '0));
		// byte count above eight stores as eight
		send_request(frame_request(OP_PUT, 29'h155_5555, 4'd15, 64'hFEDC_BA98_7654_3210));
		send_request(frame_request(OP_TAKE, '0, '0, '0));
		send_request(frame_request(OP_PUT, 29'h0AAA_AAAA, 4'd3, '1));
		send_request(frame_request(OP_UNUSED, '1, '1, '1));
		send_request(frame_request(OP_CLEAR, '0, '0, '0));
		send_request(frame_request(OP_TAKE, '0, '0, '0));
		send_request(frame_request(OP_PUT, 29'h7FF, 4'd1, 64'hA5A5_A5A5_A5A5_A5A5));
		send_request(frame_request(OP_TAKE, '0, '0, '0));
		send_request(frame_request(OP_PUT, 29'h1234567, 4'd7, {$urandom(), $urandom()}));
		send_request(frame_request(OP_TAKE, '0, '0, '0));
		settle();
	endtask

	// main sequence
	initial begin
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		sb = new();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		write_ring_length(8'd0);
		run_directed();

		// shrinks leave pointers past the new end
		run_phase(8'd255, 170, 90);
		run_phase(8'd5, 60, 50);
		run_phase(8'd1, 40, 50);
		run_phase(8'd128, 60, 25);
		run_phase(8'd2, 40, 50);
		run_phase(RING_LENGTH_W'($urandom_range(3, 127)), 60, 60);
		run_phase(RING_LENGTH_RESET, 70, 50);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("** can_frame_ring_fifo: PASSED **");
		else
			$display("** can_frame_ring_fifo: FAILED **");
		$finish;
	end

endmodule
